[rtl/ps2_scancode_to_ascii_macros.svh]
// Assertion macros shared by the scan code translator RTL.
`ifndef PS2_SCANCODE_TO_ASCII_MACROS_SVH
`define PS2_SCANCODE_TO_ASCII_MACROS_SVH

`ifndef SYNTH

// Check a property on every rising edge outside reset.
`define PS2SC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define PS2SC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define PS2SC_ASSERT(lbl, clk, rstn, prop, msg)
`define PS2SC_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

[rtl/ps2sc_pkg.sv]
// Types, scan code constants and key translation tables for the scan code translator.
`default_nettype none

package ps2sc_pkg;

    typedef logic [7:0] code_t;

    // Prefix and modifier scan codes
    localparam code_t CODE_RELEASE  = 8'hF0;
    localparam code_t CODE_EXTENDED = 8'hE0;
    localparam code_t CODE_LSHIFT   = 8'h12;
    localparam code_t CODE_RSHIFT   = 8'h59;
    localparam code_t CODE_CAPS     = 8'h58;
    localparam code_t CODE_EXT_BKSP = 8'h71;
    localparam code_t CHAR_BKSP     = 8'h08;

    // Function-key and arrow ranges
    localparam code_t FKEY_LAST = 8'h0C;
    localparam code_t SP2_FIRST = 8'h66;
    localparam code_t SP2_LAST  = 8'h83;

    localparam code_t LETTER_UPPER_BASE = 8'd65;
    localparam code_t LETTER_CASE_STEP  = 8'd32;
    localparam code_t PLAIN_RUN_BASE    = 8'h2C;
    localparam code_t SHIFT_RUN_BASE    = 8'h21;

    localparam int LETTER_N = 26;
    localparam int PLAIN_RUN_N = 18;
    localparam int SHIFT_RUN_N = 11;
    localparam int PLAIN_PAIR_N = 5;
    localparam int SHIFT_PAIR_N = 11;
    localparam int COMMON_PAIR_N = 5;
    localparam int FKEY_LOW_N = 13;
    localparam int FKEY_HIGH_N = 30;

    localparam code_t LETTER_CODES [LETTER_N] = '{
        8'h1C, 8'h32, 8'h21, 8'h23, 8'h24, 8'h2B, 8'h34, 8'h33, 8'h43, 8'h3B,
        8'h42, 8'h4B, 8'h3A, 8'h31, 8'h44, 8'h4D, 8'h15, 8'h2D, 8'h1B, 8'h2C,
        8'h3C, 8'h2A, 8'h1D, 8'h22, 8'h35, 8'h1A
    };

    // Entry i gives PLAIN_RUN_BASE + i; zero entries do match a zero code
    localparam code_t PLAIN_RUN [PLAIN_RUN_N] = '{
        8'h41, 8'h4E, 8'h49, 8'h4A, 8'h45, 8'h16, 8'h1E, 8'h26, 8'h25,
        8'h2E, 8'h36, 8'h3D, 8'h3E, 8'h46, 8'h00, 8'h4C, 8'h00, 8'h55
    };

    // Entry i gives SHIFT_RUN_BASE + i
    localparam code_t SHIFT_RUN [SHIFT_RUN_N] = '{
        8'h16, 8'h52, 8'h26, 8'h25, 8'h2E, 8'h3D, 8'h00, 8'h46, 8'h45, 8'h3E, 8'h55
    };

    localparam code_t PLAIN_PAIR_CODE [PLAIN_PAIR_N] = '{
        8'h54, 8'h5B, 8'h0E, 8'h5D, 8'h52
    };
    localparam code_t PLAIN_PAIR_CHAR [PLAIN_PAIR_N] = '{
        8'h5B, 8'h5D, 8'h60, 8'h5C, 8'h27
    };

    localparam code_t SHIFT_PAIR_CODE [SHIFT_PAIR_N] = '{
        8'h1E, 8'h36, 8'h4E, 8'h54, 8'h5B, 8'h5D, 8'h4C, 8'h41, 8'h49, 8'h4A, 8'h0E
    };
    localparam code_t SHIFT_PAIR_CHAR [SHIFT_PAIR_N] = '{
        8'h40, 8'h5E, 8'h5F, 8'h7B, 8'h7D, 8'h7C, 8'h3A, 8'h3C, 8'h3E, 8'h3F, 8'h7E
    };

    // Space, enter, tab, escape, backspace
    localparam code_t COMMON_PAIR_CODE [COMMON_PAIR_N] = '{
        8'h29, 8'h5A, 8'h0D, 8'h76, 8'h66
    };
    localparam code_t COMMON_PAIR_CHAR [COMMON_PAIR_N] = '{
        8'h20, 8'h0D, 8'h09, 8'h1B, 8'h08
    };

    localparam code_t FKEY_LOW [FKEY_LOW_N] = '{
        8'h00, 8'h88, 8'h00, 8'h84, 8'h82, 8'h80, 8'h81, 8'h8B, 8'h00, 8'h89,
        8'h87, 8'h85, 8'h83
    };

    localparam code_t FKEY_HIGH [FKEY_HIGH_N] = '{
        8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'hA1, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'hA2, 8'h00, 8'hA0, 8'hA3, 8'h00, 8'h00, 8'h8A, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h86
    };

    // Translate one key press; zero means no character.
    // Tables are searched in priority order, first hit wins.
    function automatic code_t translate_key(
        input code_t code,
        input logic  ext,
        input logic  shift,
        input logic  upper
    );
        code_t r;
        logic  hit;
        r   = '0;
        hit = 1'b0;
        if (!ext)
        begin
            for (int i = 0; i < COMMON_PAIR_N; i++)
            begin
                if (!hit && COMMON_PAIR_CODE[i] == code)
                begin
                    r   = COMMON_PAIR_CHAR[i];
                    hit = 1'b1;
                end
            end
            for (int i = 0; i < LETTER_N; i++)
            begin
                if (!hit && LETTER_CODES[i] == code)
                begin
                    r   = upper ? 8'(LETTER_UPPER_BASE + i)
                                : 8'(LETTER_UPPER_BASE + LETTER_CASE_STEP + i);
                    hit = 1'b1;
                end
            end
            if (shift)
            begin
                for (int i = 0; i < SHIFT_RUN_N; i++)
                begin
                    if (!hit && SHIFT_RUN[i] == code)
                    begin
                        r   = 8'(SHIFT_RUN_BASE + i);
                        hit = 1'b1;
                    end
                end
                for (int i = 0; i < SHIFT_PAIR_N; i++)
                begin
                    if (!hit && SHIFT_PAIR_CODE[i] == code)
                    begin
                        r   = SHIFT_PAIR_CHAR[i];
                        hit = 1'b1;
                    end
                end
            end
            else
            begin
                for (int i = 0; i < PLAIN_RUN_N; i++)
                begin
                    if (!hit && PLAIN_RUN[i] == code)
                    begin
                        r   = 8'(PLAIN_RUN_BASE + i);
                        hit = 1'b1;
                    end
                end
                for (int i = 0; i < PLAIN_PAIR_N; i++)
                begin
                    if (!hit && PLAIN_PAIR_CODE[i] == code)
                    begin
                        r   = PLAIN_PAIR_CHAR[i];
                        hit = 1'b1;
                    end
                end
            end
        end
        else if (code == CODE_EXT_BKSP)
        begin
            r   = CHAR_BKSP;
            hit = 1'b1;
        end
        // Function keys and arrows for both plain and extended codes
        if (!hit)
        begin
            if (code <= FKEY_LAST)
                r = FKEY_LOW[code[3:0]];
            else if (code >= SP2_FIRST && code <= SP2_LAST)
                r = FKEY_HIGH[5'(code - SP2_FIRST)];
            else
                r = '0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/ps2sc_code_if.sv]
// Valid/ready channel that carries one scan code byte per transfer.
`default_nettype none

interface ps2sc_code_if;
    logic              valid;
    logic              ready;
    ps2sc_pkg::code_t  scan_code;

    modport source (output valid, output scan_code, input ready);
    modport sink   (input valid, input scan_code, output ready);
endinterface

`default_nettype wire

[rtl/ps2sc_key_if.sv]
// Valid/ready channel that carries one translated key with modifier flags per transfer.
`default_nettype none

interface ps2sc_key_if;
    logic              valid;
    logic              ready;
    ps2sc_pkg::code_t  key_char;
    logic              shift_active;
    logic              caps_active;

    modport source (output valid, output key_char, output shift_active,
                    output caps_active, input ready);
    modport sink   (input valid, input key_char, input shift_active,
                    input caps_active, output ready);
endinterface

`default_nettype wire

[rtl/ps2_scancode_to_ascii.sv]
// A byte from code_in waits in the input register; any key it yields then goes to
// the result register. Throughput: one byte per cycle while the input register
// advances: the result register is free or draining, or the byte yields no key.
// Translation is one pass of table compares between the input and result registers.
// Reset (rst_n low, asynchronous) clears shift, caps lock, both prefix flags and
// both valid flags; no clearing pass is needed.
`default_nettype none

module ps2_scancode_to_ascii (
    input  wire logic         clk,
    input  wire logic         rst_n,
    ps2sc_code_if.sink        code_in,
    ps2sc_key_if.source       key_out
);

    `include "ps2_scancode_to_ascii_macros.svh"

    // Input register
    logic                     in_valid_reg;
    ps2sc_pkg::code_t         code_reg;

    // Key state
    logic                     shift_reg, shift_next;
    logic                     caps_reg, caps_next;
    logic                     ext_reg, ext_next;
    logic                     rel_reg, rel_next;

    // Result register
    logic                     out_valid_reg;
    ps2sc_pkg::code_t         key_char_reg;
    logic                     shift_out_reg;
    logic                     caps_out_reg;

    ps2sc_pkg::code_t         char_comb;
    logic                     has_result;
    logic                     advance;
    logic                     is_shift_code;

    assign is_shift_code = (code_reg == ps2sc_pkg::CODE_LSHIFT) ||
                           (code_reg == ps2sc_pkg::CODE_RSHIFT);

    assign char_comb = ps2sc_pkg::translate_key(code_reg, ext_reg, shift_reg,
                                                shift_reg ^ caps_reg);

    // Decode the held byte and work out the next key state
    always_comb
    begin
        shift_next = shift_reg;
        caps_next  = caps_reg;
        ext_next   = ext_reg;
        rel_next   = rel_reg;
        has_result = 1'b0;
        if (code_reg == ps2sc_pkg::CODE_RELEASE)
        begin
            rel_next = 1'b1;
        end
        else if (code_reg == ps2sc_pkg::CODE_EXTENDED)
        begin
            ext_next = 1'b1;
            rel_next = 1'b0;
        end
        else if (rel_reg)
        begin
            rel_next = 1'b0;
            ext_next = 1'b0;
            if (is_shift_code)
                shift_next = 1'b0;
        end
        else if (!ext_reg && is_shift_code)
        begin
            shift_next = 1'b1;
        end
        else if (!ext_reg && code_reg == ps2sc_pkg::CODE_CAPS)
        begin
            caps_next = ~caps_reg;
        end
        else
        begin
            ext_next   = 1'b0;
            has_result = (char_comb != '0);
        end
    end

    // Advance when the result slot is free, draining, or not needed
    assign advance = in_valid_reg &&
                     (!out_valid_reg || key_out.ready || !has_result);

    assign code_in.ready = !in_valid_reg || advance;

    // Hold the input and result valid flags and the key state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            shift_reg     <= 1'b0;
            caps_reg      <= 1'b0;
            ext_reg       <= 1'b0;
            rel_reg       <= 1'b0;
        end
        else
        begin
            if (code_in.ready)
                in_valid_reg <= code_in.valid;
            if (advance)
            begin
                shift_reg <= shift_next;
                caps_reg  <= caps_next;
                ext_reg   <= ext_next;
                rel_reg   <= rel_next;
            end
            if (advance && has_result)
                out_valid_reg <= 1'b1;
            else if (key_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Capture payloads on transfer
    always_ff @(posedge clk)
    begin
        if (code_in.valid && code_in.ready)
            code_reg <= code_in.scan_code;
        if (advance && has_result)
        begin
            key_char_reg  <= char_comb;
            shift_out_reg <= shift_next;
            caps_out_reg  <= caps_next;
        end
    end

    assign key_out.valid        = out_valid_reg;
    assign key_out.key_char     = key_char_reg;
    assign key_out.shift_active = shift_out_reg;
    assign key_out.caps_active  = caps_out_reg;

    // A zero translation must never reach the output
    `PS2SC_ASSERT(a_no_zero_key, clk, rst_n, key_out.valid |-> (key_out.key_char != '0), "zero key delivered")

    // A release prefix leaves the release flag set
    `PS2SC_ASSERT(a_release_sets_flag, clk, rst_n, (advance && code_reg == ps2sc_pkg::CODE_RELEASE) |=> rel_reg, "release prefix lost")

    // Caps lock moves only on an unprefixed caps key
    `PS2SC_ASSERT(a_caps_only_on_key, clk, rst_n, !(advance && code_reg == ps2sc_pkg::CODE_CAPS && !ext_reg && !rel_reg) |=> $stable(caps_reg), "caps lock changed without caps key")

    // A held byte that cannot move blocks the input
    `PS2SC_ASSERT_NEVER(a_stall_blocks_input, clk, rst_n, in_valid_reg && !advance && code_in.ready, "input taken over a stalled byte")

    // A pending result is not overwritten while waiting
    `PS2SC_ASSERT(a_result_held, clk, rst_n, (out_valid_reg && !key_out.ready) |=> (out_valid_reg && $stable(key_char_reg)), "pending key overwritten")

endmodule

`default_nettype wire

[dv/ps2_scancode_to_ascii_tb.sv]
// Self-checking testbench for the PS/2 scan code to ASCII translator.
module ps2_scancode_to_ascii_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int ITEM_TARGET = 700;
    localparam int OPENING_N = 27;

    typedef struct {
        ps2sc_pkg::code_t ch;
        logic             shift;
        logic             caps;
    } key_t;

    // Letter scan codes, A through Z
    localparam ps2sc_pkg::code_t KEY_LETTERS [26] = '{
        8'h1C, 8'h32, 8'h21, 8'h23, 8'h24, 8'h2B, 8'h34, 8'h33, 8'h43, 8'h3B,
        8'h42, 8'h4B, 8'h3A, 8'h31, 8'h44, 8'h4D, 8'h15, 8'h2D, 8'h1B, 8'h2C,
        8'h3C, 8'h2A, 8'h1D, 8'h22, 8'h35, 8'h1A
    };

    // Codes that follow an extended prefix: arrows, keypad and a few others
    localparam ps2sc_pkg::code_t EXT_KEYS [12] = '{
        ps2sc_pkg::CODE_EXT_BKSP, 8'h74, 8'h6B, 8'h72, 8'h75, 8'h70, 8'h69, 8'h7A,
        8'h7D, 8'h6C, 8'h4A, 8'h5A
    };

    // Zero codes both ways, shift and caps interplay, extended keys, extended
    // shift, function keys at both ends, the largest byte, extended release
    localparam ps2sc_pkg::code_t OPENING [OPENING_N] = '{
        8'h00, ps2sc_pkg::CODE_LSHIFT, 8'h00, 8'h1C, 8'h0E, ps2sc_pkg::CODE_RELEASE,
        ps2sc_pkg::CODE_LSHIFT, ps2sc_pkg::CODE_CAPS, 8'h1C, ps2sc_pkg::CODE_LSHIFT,
        8'h1C, ps2sc_pkg::CODE_RELEASE, ps2sc_pkg::CODE_RSHIFT, ps2sc_pkg::CODE_CAPS,
        ps2sc_pkg::CODE_EXTENDED, ps2sc_pkg::CODE_EXT_BKSP, ps2sc_pkg::CODE_EXTENDED,
        8'h74, ps2sc_pkg::CODE_EXTENDED, ps2sc_pkg::CODE_LSHIFT, 8'h05, 8'h83, 8'h07,
        8'hFF, ps2sc_pkg::CODE_EXTENDED, ps2sc_pkg::CODE_RELEASE, 8'h75
    };

    logic clk;
    logic rst_n;

    ps2sc_code_if code_if ();
    ps2sc_key_if  key_if ();

    ps2_scancode_to_ascii uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .code_in (code_if),
        .key_out (key_if)
    );

    // Keyboard state as the translator should track it
    logic shift_held;
    logic caps_lock;
    logic ext_pend;
    logic release_pend;

    ps2sc_pkg::code_t pending_codes [$];
    key_t             expected_keys [$];

    int errors = 0;
    int press_bytes = 0;
    int bytes_sent = 0;
    int keys_checked = 0;
    int shifted_keys = 0;
    int caps_keys = 0;
    int hold_offs = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_cycles = 0;

    int rx_cycles;
    int hold_left;
    int mode_left;
    int stall_mode;

    // Character for one key press; zero means the press gives nothing
    function automatic ps2sc_pkg::code_t lookup_char(ps2sc_pkg::code_t code, logic ext,
                                                     logic shift, logic caps);
        ps2sc_pkg::code_t r;
        r = 8'h00;
        if (!ext)
        begin
            case (code)
                8'h29: r = 8'h20;
                8'h5A: r = 8'h0D;
                8'h0D: r = 8'h09;
                8'h76: r = 8'h1B;
                8'h66: r = 8'h08;
                default: ;
            endcase
            for (int i = 0; i < 26; i++)
            begin
                if (r == 8'h00 && KEY_LETTERS[i] == code)
                    r = (shift ^ caps) ? 8'(8'h41 + i) : 8'(8'h61 + i);
            end
            if (r == 8'h00 && shift)
            begin
                case (code)
                    8'h16: r = 8'h21;
                    8'h52: r = 8'h22;
                    8'h26: r = 8'h23;
                    8'h25: r = 8'h24;
                    8'h2E: r = 8'h25;
                    8'h3D: r = 8'h26;
                    8'h00: r = 8'h27;
                    8'h46: r = 8'h28;
                    8'h45: r = 8'h29;
                    8'h3E: r = 8'h2A;
                    8'h55: r = 8'h2B;
                    8'h1E: r = 8'h40;
                    8'h36: r = 8'h5E;
                    8'h4E: r = 8'h5F;
                    8'h54: r = 8'h7B;
                    8'h5B: r = 8'h7D;
                    8'h5D: r = 8'h7C;
                    8'h4C: r = 8'h3A;
                    8'h41: r = 8'h3C;
                    8'h49: r = 8'h3E;
                    8'h4A: r = 8'h3F;
                    8'h0E: r = 8'h7E;
                    default: ;
                endcase
            end
            else if (r == 8'h00)
            begin
                case (code)
                    8'h41: r = 8'h2C;
                    8'h4E: r = 8'h2D;
                    8'h49: r = 8'h2E;
                    8'h4A: r = 8'h2F;
                    8'h45: r = 8'h30;
                    8'h16: r = 8'h31;
                    8'h1E: r = 8'h32;
                    8'h26: r = 8'h33;
                    8'h25: r = 8'h34;
                    8'h2E: r = 8'h35;
                    8'h36: r = 8'h36;
                    8'h3D: r = 8'h37;
                    8'h3E: r = 8'h38;
                    8'h46: r = 8'h39;
                    8'h00: r = 8'h3A;
                    8'h4C: r = 8'h3B;
                    8'h55: r = 8'h3D;
                    8'h54: r = 8'h5B;
                    8'h5B: r = 8'h5D;
                    8'h0E: r = 8'h60;
                    8'h5D: r = 8'h5C;
                    8'h52: r = 8'h27;
                    default: ;
                endcase
            end
        end
        else if (code == ps2sc_pkg::CODE_EXT_BKSP)
            r = ps2sc_pkg::CHAR_BKSP;
        // Function keys and arrows, plain or extended
        if (r == 8'h00)
        begin
            case (code)
                8'h01: r = 8'h88;
                8'h03: r = 8'h84;
                8'h04: r = 8'h82;
                8'h05: r = 8'h80;
                8'h06: r = 8'h81;
                8'h07: r = 8'h8B;
                8'h09: r = 8'h89;
                8'h0A: r = 8'h87;
                8'h0B: r = 8'h85;
                8'h0C: r = 8'h83;
                8'h66: r = 8'h08;
                8'h6B: r = 8'hA1;
                8'h72: r = 8'hA2;
                8'h74: r = 8'hA0;
                8'h75: r = 8'hA3;
                8'h78: r = 8'h8A;
                8'h83: r = 8'h86;
                default: ;
            endcase
        end
        return r;
    endfunction

    // Advance the keyboard state by one byte and queue the key it yields
    task automatic predict_key(ps2sc_pkg::code_t code);
        key_t k;
        if (code == ps2sc_pkg::CODE_RELEASE)
            release_pend = 1'b1;
        else if (code == ps2sc_pkg::CODE_EXTENDED)
        begin
            ext_pend = 1'b1;
            release_pend = 1'b0;
        end
        else if (release_pend)
        begin
            release_pend = 1'b0;
            ext_pend = 1'b0;
            if (code == ps2sc_pkg::CODE_LSHIFT || code == ps2sc_pkg::CODE_RSHIFT)
                shift_held = 1'b0;
        end
        else if (!ext_pend &&
                 (code == ps2sc_pkg::CODE_LSHIFT || code == ps2sc_pkg::CODE_RSHIFT))
            shift_held = 1'b1;
        else if (!ext_pend && code == ps2sc_pkg::CODE_CAPS)
            caps_lock = !caps_lock;
        else
        begin
            k.ch = lookup_char(code, ext_pend, shift_held, caps_lock);
            ext_pend = 1'b0;
            if (k.ch != 8'h00)
            begin
                k.shift = shift_held;
                k.caps = caps_lock;
                expected_keys.push_back(k);
            end
        end
    endtask

    task automatic report_mismatch(string what, ps2sc_pkg::code_t got,
                                   ps2sc_pkg::code_t want);
        $display("MISMATCH at %0t: %s got %02h expected %02h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic queue_byte(ps2sc_pkg::code_t b);
        pending_codes.push_back(b);
        if (b != ps2sc_pkg::CODE_RELEASE && b != ps2sc_pkg::CODE_EXTENDED)
            press_bytes++;
    endtask

    // Letters half the time, otherwise anything up to the top of the arrow range
    function automatic ps2sc_pkg::code_t pick_key();
        if ($urandom_range(0, 1) == 0)
            return KEY_LETTERS[$urandom_range(0, 25)];
        return 8'($urandom_range(0, 8'h83));
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Drive scan codes in bursts, most of them separated by idle gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_if.valid <= 1'b0;
            code_if.scan_code <= 8'h00;
        end
        else
        begin
            if (code_if.valid && code_if.ready)
            begin
                predict_key(code_if.scan_code);
                bytes_sent++;
            end
            if (code_if.valid && !code_if.ready)
                ;
            else if (gap_left != 0)
            begin
                gap_left--;
                code_if.valid <= 1'b0;
            end
            else if (pending_codes.size() != 0)
            begin
                code_if.valid <= 1'b1;
                code_if.scan_code <= pending_codes.pop_front();
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 32);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                code_if.valid <= 1'b0;
        end
    end

    // Stall the key output on shifting patterns, with two long hold-offs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_if.ready <= 1'b0;
            rx_cycles <= 0;
            hold_left <= 0;
            mode_left <= 0;
            stall_mode <= 0;
        end
        else
        begin
            rx_cycles <= rx_cycles + 1;
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                key_if.ready <= 1'b0;
            end
            else if (rx_cycles == 250 || rx_cycles == 600)
            begin
                hold_left <= HOLD_OFF_CYCLES;
                hold_offs++;
                key_if.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode <= $urandom_range(0, 3);
                    mode_left <= $urandom_range(16, 96);
                end
                else
                    mode_left <= mode_left - 1;
                case (stall_mode)
                    0: key_if.ready <= 1'b1;
                    1: key_if.ready <= ($urandom_range(0, 3) != 0);
                    2: key_if.ready <= (rx_cycles % 3 != 0);
                    default: key_if.ready <= ($urandom_range(0, 1) != 0);
                endcase
            end
        end
    end

    // Compare each key transfer with the oldest expected key
    always @(posedge clk)
    begin : check_keys
        key_t want;
        if (rst_n && key_if.valid && key_if.ready)
        begin
            if (expected_keys.size() == 0)
                report_mismatch("unexpected key", key_if.key_char, 8'h00);
            else
            begin
                want = expected_keys.pop_front();
                keys_checked++;
                if (key_if.key_char !== want.ch)
                    report_mismatch("key_char", key_if.key_char, want.ch);
                if (key_if.shift_active !== want.shift)
                    report_mismatch("shift_active", 8'(key_if.shift_active), 8'(want.shift));
                if (key_if.caps_active !== want.caps)
                    report_mismatch("caps_active", 8'(key_if.caps_active), 8'(want.caps));
                if (want.shift)
                    shifted_keys++;
                if (want.caps)
                    caps_keys++;
            end
        end
    end

    // End the run when neither channel has moved for too long
    always @(posedge clk)
    begin
        if (!rst_n || (code_if.valid && code_if.ready) || (key_if.valid && key_if.ready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles, %0d keys still expected",
                         STALL_LIMIT, expected_keys.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        ps2sc_pkg::code_t k;
        ps2sc_pkg::code_t s;
        rst_n = 1'b0;
        shift_held = 1'b0;
        caps_lock = 1'b0;
        ext_pend = 1'b0;
        release_pend = 1'b0;

        foreach (OPENING[i])
            queue_byte(OPENING[i]);

        // Mostly well-formed key sequences, with noise and broken prefixes mixed in
        while (pending_codes.size() < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    k = pick_key();
                    queue_byte(k);
                    queue_byte(ps2sc_pkg::CODE_RELEASE);
                    queue_byte(k);
                end
                4, 5:
                begin
                    s = ($urandom_range(0, 1) != 0) ? ps2sc_pkg::CODE_LSHIFT
                                                    : ps2sc_pkg::CODE_RSHIFT;
                    queue_byte(s);
                    repeat ($urandom_range(1, 4))
                    begin
                        k = pick_key();
                        queue_byte(k);
                        queue_byte(ps2sc_pkg::CODE_RELEASE);
                        queue_byte(k);
                    end
                    queue_byte(ps2sc_pkg::CODE_RELEASE);
                    queue_byte(s);
                end
                6:
                begin
                    queue_byte(ps2sc_pkg::CODE_CAPS);
                    queue_byte(ps2sc_pkg::CODE_RELEASE);
                    queue_byte(ps2sc_pkg::CODE_CAPS);
                end
                7:
                begin
                    k = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 8'h83))
                                                    : EXT_KEYS[$urandom_range(0, 11)];
                    queue_byte(ps2sc_pkg::CODE_EXTENDED);
                    queue_byte(k);
                    queue_byte(ps2sc_pkg::CODE_EXTENDED);
                    queue_byte(ps2sc_pkg::CODE_RELEASE);
                    queue_byte(k);
                end
                8:
                    queue_byte(8'($urandom_range(0, 255)));
                default:
                begin
                    k = pick_key();
                    case ($urandom_range(0, 5))
                        0:
                        begin
                            queue_byte(ps2sc_pkg::CODE_RELEASE);
                            queue_byte(ps2sc_pkg::CODE_RELEASE);
                        end
                        1:
                        begin
                            queue_byte(ps2sc_pkg::CODE_EXTENDED);
                            queue_byte(ps2sc_pkg::CODE_EXTENDED);
                        end
                        2:
                        begin
                            queue_byte(ps2sc_pkg::CODE_RELEASE);
                            queue_byte(ps2sc_pkg::CODE_EXTENDED);
                        end
                        3:
                        begin
                            queue_byte(ps2sc_pkg::CODE_EXTENDED);
                            queue_byte(ps2sc_pkg::CODE_LSHIFT);
                        end
                        4:
                        begin
                            queue_byte(ps2sc_pkg::CODE_EXTENDED);
                            queue_byte(ps2sc_pkg::CODE_CAPS);
                        end
                        default:
                        begin
                            queue_byte(ps2sc_pkg::CODE_EXTENDED);
                            queue_byte(ps2sc_pkg::CODE_RELEASE);
                            queue_byte(ps2sc_pkg::CODE_RSHIFT);
                        end
                    endcase
                    queue_byte(k);
                end
            endcase
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: wait until all bytes are sent and all keys are back, then report
        while (pending_codes.size() != 0 || code_if.valid)
            @(posedge clk);
        while (expected_keys.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d scan code bytes (%0d non-prefix), checked %0d keys",
                 bytes_sent, press_bytes, keys_checked);
        $display("Keys with shift: %0d, with caps lock: %0d, output hold-offs: %0d, errors: %0d",
                 shifted_keys, caps_keys, hold_offs, errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
